// File: rtl/etm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_pkg
// shared types and constants of the execution time monitor
// ----------------------------------------------------------------------------
package etm_pkg;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic [31:0] MIN_RESET_VALUE = 32'd20000000;
  localparam int unsigned MAX_LINES = 16;

  // transaction carried from the front part to the back part
  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  pid;
    logic [31:0] stamp;
  } etm_op_t;

endpackage

// File: rtl/etm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_ram
// generic ram with one write port and a separate registered read port
// ----------------------------------------------------------------------------
module etm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/etm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_front
// accepts transactions, drops unused ones, and queues the rest
// ----------------------------------------------------------------------------
module etm_front #(
  parameter int unsigned NumProcesses = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [1:0]       command_i,
  input  logic [3:0]       process_id_i,
  input  logic [31:0]      timestamp_i,
  output logic             op_valid_o,
  input  logic             op_pop_i,
  output etm_pkg::etm_op_t op_o
);
  import etm_pkg::*;

  localparam int unsigned Depth = 2;

  etm_op_t     fifo_q [Depth];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        accept, keep;

  assign stall_o = (cnt_q == 2'(Depth));
  assign accept  = valid_i && !stall_o;
  // starts and ends of processes out of range and the unused command do nothing
  always_comb begin
    keep = 1'b0;
    case (command_i)
      CMD_START, CMD_END: keep = (32'(process_id_i) < NumProcesses);
      CMD_REPORT:         keep = 1'b1;
      default:            keep = 1'b0;
    endcase
  end

  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      fifo_q[wptr_q].cmd   <= command_i;
      fifo_q[wptr_q].pid   <= {2'b00, process_id_i};
      fifo_q[wptr_q].stamp <= timestamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (accept && keep) begin
        wptr_q <= ~wptr_q;
      end
      if (op_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(accept && keep) - 2'(op_pop_i);
    end
  end
endmodule

// File: rtl/etm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_div
// restoring divider, one quotient bit per cycle, 64 by 36 bits
// ----------------------------------------------------------------------------
module etm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [35:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [35:0] rem_o
);
  logic [63:0] quo_q;
  logic [36:0] rem_q;
  logic [35:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [36:0] shifted, diff;

  assign shifted = {rem_q[35:0], quo_q[63]};
  assign diff    = shifted - {1'b0, den_q};
  assign quo_o   = quo_q;
  assign rem_o   = rem_q[35:0];
  assign done_o  = busy_q && (cnt_q == 7'd0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (!diff[36]) begin
        rem_q <= diff;
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end
endmodule

// File: rtl/etm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_back
// per-process statistics update and report sequencer
// ----------------------------------------------------------------------------
module etm_back #(
  parameter int unsigned NumProcesses = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      min_start_i,
  input  logic             op_valid_i,
  output logic             op_pop_o,
  input  etm_pkg::etm_op_t op_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [3:0]       report_process_o,
  output logic [31:0]      calls_o,
  output logic [31:0]      min_time_o,
  output logic [31:0]      max_time_o,
  output logic [31:0]      average_time_o,
  output logic             last_o
);
  import etm_pkg::*;

  localparam int unsigned AW = (NumProcesses > 1) ? $clog2(NumProcesses) : 1;
  localparam int unsigned Lines = (NumProcesses < MAX_LINES) ? NumProcesses : MAX_LINES;
  localparam int unsigned SW = 32 + 32 + 32 + 64 + 32;

  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_UPD = 4'd2,
                         S_RREAD = 4'd3, S_RLOAD = 4'd4, S_SCALE = 4'd5,
                         S_DIV = 4'd6, S_FRAC = 4'd7, S_FDIV = 4'd8,
                         S_OUT = 4'd9, S_CLR = 4'd10;

  logic [3:0]    state_q;
  logic [AW-1:0] idx_q;
  logic          wait_q;
  // valid bits stand in for the reset value of each entry
  logic [NumProcesses-1:0] vld_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wdata, rdata;
  logic [AW-1:0] op_idx;

  logic [31:0] st_q, mn_q, mx_q, cn_q;
  logic [63:0] sm_q;
  logic [63:0] quo_q;
  logic [35:0] den_q, rem_q;
  logic        div_start;
  logic [63:0] div_num;
  logic [35:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;
  logic [35:0] div_rem;
  logic [31:0] dt;
  logic [38:0] mn_s, mx_s;
  logic [73:0] tot;
  logic [45:0] rk;

  assign op_idx = op_i.pid[AW-1:0];

  etm_ram #(.Width(SW), .Depth(NumProcesses)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  etm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // the entry of the queued op is read in idle and read again so it is there in update
  assign raddr = (state_q == S_IDLE || state_q == S_READ) ? op_idx : idx_q;
  assign dt    = op_i.stamp - st_q;

  // entry fields, valid bit substitutes reset values
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD || state_q == S_RLOAD) begin
      if (vld_q[state_q == S_UPD ? op_idx : idx_q]) begin
        {st_q, mn_q, mx_q, sm_q, cn_q} <= rdata;
      end else begin
        st_q <= '0;
        mn_q <= MIN_RESET_VALUE;
        mx_q <= '0;
        sm_q <= '0;
        cn_q <= '0;
      end
    end
  end

  // next state writes
  always_comb begin
    we    = 1'b0;
    waddr = op_idx;
    wdata = '0;
    if (state_q == S_UPD) begin
      we = 1'b1;
      if (op_i.cmd == CMD_START) begin
        wdata = {op_i.stamp, (vld_q[op_idx] ? rdata[SW-33 -: 32] : MIN_RESET_VALUE),
                 (vld_q[op_idx] ? rdata[127:0] : 128'd0)};
      end else begin
        we = 1'b0;
      end
    end else if (state_q == S_IDLE && wait_q) begin
      // end: stage registers hold the entry
      we = 1'b1;
      wdata = {st_q, (dt < mn_q) ? dt : mn_q, (dt > mx_q) ? dt : mx_q,
               sm_q + 64'(dt), cn_q + 32'd1};
    end else if (state_q == S_CLR) begin
      // report clear keeps the start stamp
      we    = 1'b1;
      waddr = idx_q;
      wdata = {st_q, min_start_i, 128'd0};
    end
  end

  assign mn_s = {mn_q, 7'd0} - {2'b0, mn_q, 5'd0} + {5'b0, mn_q, 2'd0}; // x100
  assign mx_s = {mx_q, 7'd0} - {2'b0, mx_q, 5'd0} + {5'b0, mx_q, 2'd0};
  assign rk   = {rem_q, 10'd0} - {5'b0, rem_q, 5'd0} + {7'b0, rem_q, 3'd0}
                + {11'b0, den_q[35:1]};
  assign tot  = {quo_q, 10'd0} - {5'b0, quo_q, 5'd0} + {7'b0, quo_q, 3'd0}
                + 74'(div_quo);

  assign div_start = (state_q == S_SCALE && cn_q != 0) ||
                     (state_q == S_FRAC);
  assign div_num   = (state_q == S_FRAC) ? 64'(rk) : sm_q;
  assign div_den   = (state_q == S_SCALE) ? {cn_q, 4'd0} : den_q;

  assign op_pop_o = (state_q == S_UPD) && (op_i.cmd == CMD_START) ||
                    (state_q == S_IDLE && wait_q) ||
                    (state_q == S_CLR && 32'(idx_q) == NumProcesses - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      wait_q    <= 1'b0;
      vld_q     <= '0;
      valid_o   <= 1'b0;
    end else begin
      wait_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (wait_q) begin
            vld_q[op_idx] <= 1'b1;
          end else if (op_valid_i) begin
            if (op_i.cmd == CMD_REPORT) begin
              idx_q   <= '0;
              state_q <= S_RREAD;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_UPD;
        S_UPD: begin
          if (op_i.cmd == CMD_START) begin
            vld_q[op_idx] <= 1'b1;
          end else begin
            wait_q <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_RREAD: state_q <= S_RLOAD;
        S_RLOAD: state_q <= S_SCALE;
        S_SCALE: begin
          state_q <= (cn_q == 0) ? S_OUT : S_DIV;
        end
        S_DIV: if (div_done) state_q <= S_FRAC;
        S_FRAC: state_q <= S_FDIV;
        S_FDIV: if (div_done) state_q <= S_OUT;
        S_OUT: begin
          if (32'(idx_q) < Lines) begin
            if (!valid_o || !stall_i) begin
              valid_o <= 1'b1;
              state_q <= S_CLR;
            end
          end else begin
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          if (!valid_o || !stall_i) begin
            valid_o <= valid_o && stall_i;
          end
          vld_q[idx_q] <= 1'b1;
          if (32'(idx_q) == NumProcesses - 1) begin
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_RREAD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (!(state_q == S_OUT && 32'(idx_q) < Lines) && state_q != S_CLR &&
          valid_o && !stall_i) begin
        valid_o <= 1'b0;
      end
    end
  end

  // divider operands and report line
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCALE) begin
      den_q <= {cn_q, 4'd0};
    end
    if (state_q == S_DIV && div_done) begin
      quo_q <= div_quo;
      rem_q <= div_rem;
    end
    if (state_q == S_OUT && 32'(idx_q) < Lines && (!valid_o || !stall_i)) begin
      report_process_o <= 4'(idx_q);
      calls_o          <= cn_q;
      min_time_o       <= (|mn_s[38:36]) ? '1 : mn_s[35:4];
      max_time_o       <= (|mx_s[38:36]) ? '1 : mx_s[35:4];
      if (cn_q == 0) begin
        average_time_o <= '0;
      end else if (quo_q > 64'd4294967) begin
        average_time_o <= '1;
      end else begin
        average_time_o <= (|tot[73:32]) ? '1 : tot[31:0];
      end
      last_o <= (32'(idx_q) == Lines - 1);
    end
  end
endmodule

// File: rtl/execution_time_min_max_avg_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// execution_time_min_max_avg_monitor
// per-process execution time statistics with min, max and rounded average
// ----------------------------------------------------------------------------
// a start or end transaction passes through ram read, field load and write
// back in the back part; the front queue takes one per cycle while not full
// a report walks every process; a line with calls takes the two passes of
// the shared bit-serial divider, a line without calls skips the divider
// asynchronous active-low reset clears control state, entries read as reset
// values through per-process valid bits, no clearing pass
module execution_time_min_max_avg_monitor #(
  parameter int unsigned NUM_PROCESSES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  process_id_i,
  input  logic [31:0] timestamp_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [3:0]  report_process_o,
  output logic [31:0] calls_o,
  output logic [31:0] min_time_o,
  output logic [31:0] max_time_o,
  output logic [31:0] average_time_o,
  output logic        last_o
);
  import etm_pkg::*;

  logic [31:0] min_start_q;
  logic        op_valid, op_pop;
  etm_op_t     op;

  // minimum restart value register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_start_q <= MIN_RESET_VALUE;
    end else if (cfg_we_i) begin
      min_start_q <= cfg_wdata_i;
    end
  end

  // front: accept and filter transactions into a short queue
  etm_front #(.NumProcesses(NUM_PROCESSES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .command_i   (command_i),
    .process_id_i(process_id_i),
    .timestamp_i (timestamp_i),
    .op_valid_o  (op_valid),
    .op_pop_i    (op_pop),
    .op_o        (op)
  );

  // back: statistics update and report generation
  etm_back #(.NumProcesses(NUM_PROCESSES)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .min_start_i     (min_start_q),
    .op_valid_i      (op_valid),
    .op_pop_o        (op_pop),
    .op_i            (op),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .report_process_o(report_process_o),
    .calls_o         (calls_o),
    .min_time_o      (min_time_o),
    .max_time_o      (max_time_o),
    .average_time_o  (average_time_o),
    .last_o          (last_o)
  );
endmodule

// File: rtl/etm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_checker
// port-level checks of the monitor
// ----------------------------------------------------------------------------
module etm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic [3:0]  report_process_o,
  input logic [31:0] calls_o,
  input logic [31:0] average_time_o,
  input logic        last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(report_process_o))
    else $error("stalled line changed");
  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && calls_o == 32'd0 |-> average_time_o == 32'd0)
    else $error("average without calls");
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_o |=> !valid_o || report_process_o != 4'd0)
    else $error("report restarted early");
endmodule

bind execution_time_min_max_avg_monitor etm_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_o         (valid_o),
  .stall_i         (stall_i),
  .report_process_o(report_process_o),
  .calls_o         (calls_o),
  .average_time_o  (average_time_o),
  .last_o          (last_o)
);

// File: test/tb_execution_time_min_max_avg_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_execution_time_min_max_avg_monitor
// self-checking bench for the per-process execution time monitor
// ----------------------------------------------------------------------------
// start/end pairs with random content drive the per-process statistics and
// report transactions dump them; a local model of the statistics predicts
// every report line, which is compared field by field in arrival order
// both channels idle at random, and the reset value of the minimum is
// rewritten between reports while the block is idle
module tb_execution_time_min_max_avg_monitor;
  import etm_pkg::*;

  localparam int unsigned NPROC     = 16;
  localparam logic [1:0]  CMD_SPARE = 2'd3;  // unused command, ignored
  localparam int unsigned SETTLE    = 300;   // drain time for queued start/end
  localparam int unsigned LIMIT     = 2000000;

  typedef struct {
    logic [3:0]  proc;
    logic [31:0] calls;
    logic [31:0] min_t;
    logic [31:0] max_t;
    logic [31:0] avg_t;
    logic        last;
  } report_line_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  command_i = CMD_START;
  logic [3:0]  process_id_i = '0;
  logic [31:0] timestamp_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [3:0]  report_process_o;
  logic [31:0] calls_o, min_time_o, max_time_o, average_time_o;
  logic        last_o;

  execution_time_min_max_avg_monitor #(.NUM_PROCESSES(NPROC)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .valid_i, .stall_o, .command_i, .process_id_i, .timestamp_i,
    .valid_o, .stall_i, .report_process_o, .calls_o, .min_time_o,
    .max_time_o, .average_time_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the statistics
  logic [31:0] min_restart;
  logic [31:0] stamp_q [NPROC];
  logic [31:0] min_q   [NPROC];
  logic [31:0] max_q   [NPROC];
  logic [63:0] sum_q   [NPROC];
  logic [31:0] calls_q [NPROC];

  report_line_t pending_lines[$];
  int unsigned  err_count = 0;
  int unsigned  cycle_count = 0;
  bit           quiet = 1'b0;  // no new idling starts on either side while set
  int unsigned  stall_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic logic [31:0] to_hundredths(input logic [31:0] counts);
    logic [63:0] v;
    v = ({32'd0, counts} * 64'd100) / 64'd16;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] avg_thousandths(input logic [63:0] sum,
                                                  input logic [31:0] n);
    logic [63:0] d, q, r, total;
    if (n == 0) return '0;
    d = {32'd0, n} * 64'd16;
    q = sum / d;
    r = sum % d;
    if (q > 64'd4294967) return 32'hFFFF_FFFF;
    total = q * 64'd1000 + (r * 64'd1000 + d / 2) / d;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  task automatic clear_model();
    min_restart = MIN_RESET_VALUE;
    for (int i = 0; i < NPROC; i++) begin
      stamp_q[i] = '0; min_q[i] = MIN_RESET_VALUE; max_q[i] = '0;
      sum_q[i] = '0; calls_q[i] = '0;
    end
  endtask

  // apply one accepted transaction to the statistics
  task automatic update_stats(input logic [1:0] cmd, input logic [3:0] pid,
                              input logic [31:0] ts);
    logic [31:0]  dt;
    report_line_t ln;
    case (cmd)
      CMD_START: stamp_q[pid] = ts;
      CMD_END: begin
        dt = ts - stamp_q[pid];
        if (dt < min_q[pid]) min_q[pid] = dt;
        if (dt > max_q[pid]) max_q[pid] = dt;
        sum_q[pid] += {32'd0, dt};
        calls_q[pid] += 32'd1;
      end
      CMD_REPORT: begin
        for (int i = 0; i < NPROC; i++) begin
          ln.proc  = i[3:0];
          ln.calls = calls_q[i];
          ln.min_t = to_hundredths(min_q[i]);
          ln.max_t = to_hundredths(max_q[i]);
          ln.avg_t = avg_thousandths(sum_q[i], calls_q[i]);
          ln.last  = (i == NPROC - 1);
          pending_lines.push_back(ln);
          min_q[i] = min_restart; max_q[i] = '0; sum_q[i] = '0; calls_q[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 11) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  // one input transaction: valid stays high into the next one when no gap
  task automatic send_item(input logic [1:0] cmd, input logic [3:0] pid,
                           input logic [31:0] ts);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i = 1'b1; command_i = cmd; process_id_i = pid; timestamp_i = ts;
    do @(posedge clk_i); while (stall_o);
    update_stats(cmd, pid, ts);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    valid_i = 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_min_restart(input logic [31:0] value);
    wait_idle();
    cfg_we_i = 1'b1; cfg_wdata_i = value;
    @(posedge clk_i);
    min_restart = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // output side stall: mostly short bursts, now and then a long one
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) < 3) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 2);
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    report_line_t w;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_lines.size() == 0) begin
        report_mismatch("unexpected line", 32'(report_process_o), '0);
      end else begin
        w = pending_lines.pop_front();
        if (report_process_o !== w.proc)
          report_mismatch("process", 32'(report_process_o), 32'(w.proc));
        if (calls_o !== w.calls) report_mismatch("calls", calls_o, w.calls);
        if (min_time_o !== w.min_t) report_mismatch("min_time", min_time_o, w.min_t);
        if (max_time_o !== w.max_t) report_mismatch("max_time", max_time_o, w.max_t);
        if (average_time_o !== w.avg_t)
          report_mismatch("average_time", average_time_o, w.avg_t);
        if (last_o !== w.last) report_mismatch("last", 32'(last_o), 32'(w.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("[execution_time_min_max_avg_monitor] ERROR");
      $finish;
    end
  end

  // one measured execution of a process
  task automatic run_once(input logic [3:0] pid, input logic [31:0] dt);
    logic [31:0] t0;
    t0 = $urandom;
    send_item(CMD_START, pid, t0);
    send_item(CMD_END, pid, t0 + dt);
  endtask

  // field extremes, every command and the corner cases
  task automatic test_directed();
    quiet = 1'b1;
    send_item(CMD_REPORT, 4'd0, '0);                 // empty report, average 0
    send_item(CMD_END, 4'd3, 32'd1600);              // end without a start
    run_once(4'd0, 32'd0);
    run_once(4'd0, 32'hFFFF_FFFF);                   // saturated max and average
    run_once(4'd15, 32'd1);
    run_once(4'd15, 32'd24);                         // average with a fraction to round
    send_item(CMD_START, 4'd7, 32'hFFFF_FFF0);
    send_item(CMD_END, 4'd7, 32'h0000_0010);         // timer wrap
    send_item(CMD_SPARE, 4'd7, 32'hFFFF_FFFF);       // ignored
    send_item(CMD_START, 4'd9, 32'h5555_5555);
    send_item(CMD_END, 4'd9, 32'hAAAA_AAAA);
    send_item(CMD_REPORT, 4'd15, 32'hFFFF_FFFF);
    quiet = 1'b0;
  endtask

  task automatic test_config_settings();
    logic [31:0] vals [4];
    vals = '{32'd0, 32'hFFFF_FFFF, $urandom, MIN_RESET_VALUE};
    foreach (vals[k]) begin
      write_min_restart(vals[k]);
      send_item(CMD_REPORT, 4'($urandom), $urandom); // clears to new value
      if (k[0]) run_once(4'($urandom), $urandom_range(0, 2000));
      send_item(CMD_REPORT, 4'($urandom), $urandom);
    end
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned sel;
    logic [31:0] dt;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        case ($urandom_range(0, 9))
          0:       dt = $urandom;
          1:       dt = $urandom_range(687194767, 32'hFFFF_FFFF);
          2, 3:    dt = $urandom_range(0, 15);
          default: dt = $urandom_range(16, 200000);
        endcase
        run_once(4'($urandom), dt);
        sent += 2;
      end else if (sel < 90) begin
        send_item(2'($urandom), 4'($urandom), $urandom);  // noise
        sent++;
      end else begin
        send_item(CMD_REPORT, 4'($urandom), $urandom);
        sent++;
      end
      if (sent % 90 < 2 && $urandom_range(0, 1)) begin
        quiet = ~quiet;
      end
    end
    quiet = 1'b0;
    send_item(CMD_REPORT, 4'd0, '0);
  endtask

  // sender holds off until every report line has drained
  task automatic test_pressure();
    run_once(4'd5, 32'd320);
    send_item(CMD_REPORT, 4'd5, '0);
    valid_i = 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    run_once(4'd5, 32'd480);
    send_item(CMD_REPORT, 4'd5, '0);
  endtask

  initial begin
    clear_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_settings();
    test_random(200);
    test_pressure();
    write_min_restart($urandom);
    test_random(40);
    valid_i = 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[execution_time_min_max_avg_monitor] OK");
    end else begin
      $display("[execution_time_min_max_avg_monitor] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/etm_pkg.sv
rtl/etm_ram.sv
rtl/etm_front.sv
rtl/etm_div.sv
rtl/etm_back.sv
rtl/execution_time_min_max_avg_monitor.sv
rtl/etm_checker.sv
test/tb_execution_time_min_max_avg_monitor.sv
